// ----- design/dcpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dcpm_pkg
// Shared widths, register indexes and types of the drive command plant model.
// ----------------------------------------------------------------------------
package dcpm_pkg;

   localparam int QW       = 21;        // quotient bits of the dead-zone rescale
   localparam int DIFF_W   = 18;        // magnitude above dead zone, Q.16
   localparam int DIV_W    = 17;        // 1 - dz, Q.16
   localparam int DIV_STAGES = QW;      // one quotient bit per stage

   localparam logic [15:0] DZ_MAX = 16'd62259;
   localparam logic [QW-1:0] E_LIMIT = 21'd1441792;   // 22.0 in Q.16

   localparam logic [2:0] REG_LIN_DZ    = 3'd0;
   localparam logic [2:0] REG_ANG_DZ    = 3'd1;
   localparam logic [2:0] REG_LIN_GAIN  = 3'd2;
   localparam logic [2:0] REG_ANG_GAIN  = 3'd3;
   localparam logic [2:0] REG_SPD_LOSS  = 3'd4;
   localparam logic [2:0] REG_YAW_LOSS  = 3'd5;
   localparam logic [2:0] REG_DRIFT     = 3'd6;
   localparam logic [2:0] REG_DRIFT_OFS = 3'd7;

   typedef struct packed {
      logic              neg;
      logic [DIFF_W-1:0] diff;
      logic [DIV_W-1:0]  divisor;
   } prep_type;

endpackage

// ----- design/dcpm_req_if.sv -----
// ----------------------------------------------------------------------------
// dcpm_req_if
// Command channel: one word carries a linear and a turn command.
// ----------------------------------------------------------------------------
interface dcpm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] linear_command;
   logic signed [15:0] turn_command;

   modport source (output valid, output linear_command, output turn_command, input ready);
   modport sink   (input valid, input linear_command, input turn_command, output ready);
endinterface

// ----- design/dcpm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dcpm_rsp_if
// Result channel: one word carries linear velocity and yaw rate.
// ----------------------------------------------------------------------------
interface dcpm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] linear_velocity;
   logic signed [31:0] yaw_rate;

   modport source (output valid, output linear_velocity, output yaw_rate, input ready);
   modport sink   (input valid, input linear_velocity, input yaw_rate, output ready);
endinterface

// ----- design/dcpm_div.sv -----
// ----------------------------------------------------------------------------
// dcpm_div
// Pipelined restoring divider, floor((diff << 16) / divisor), one bit a stage.
// ----------------------------------------------------------------------------
module dcpm_div
   import dcpm_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [DIFF_W-1:0] diff_in,
   input  logic [DIV_W-1:0]  div_in,
   output logic [QW-1:0]     quo_out
);

   localparam int LO_W = QW - 16;

   logic [DIV_W-1:0] rem_ff [DIV_STAGES];
   logic [QW-1:0]    quo_ff [DIV_STAGES];
   logic [DIV_W-1:0] dv_ff  [DIV_STAGES];
   logic [LO_W-1:0]  lo_ff  [DIV_STAGES];

   genvar j;
   generate
      for (j = 0; j < DIV_STAGES; j++) begin : g_stage
         logic [DIV_W-1:0] rem_src;
         logic [QW-1:0]    quo_src;
         logic [DIV_W-1:0] dv_src;
         logic [LO_W-1:0]  lo_src;
         logic             nbit;
         logic [DIV_W:0]   trial;
         logic             ge;
         logic [DIV_W:0]   sub;
         logic [DIV_W-1:0] rem_in;
         logic [QW-1:0]    quo_in;

         if (j == 0) begin : g_first
            assign rem_src = DIV_W'(diff_in[DIFF_W-1:LO_W]);
            assign quo_src = '0;
            assign dv_src  = div_in;
            assign lo_src  = diff_in[LO_W-1:0];
         end else begin : g_next
            assign rem_src = rem_ff[j-1];
            assign quo_src = quo_ff[j-1];
            assign dv_src  = dv_ff[j-1];
            assign lo_src  = lo_ff[j-1];
         end

         if (j < LO_W) begin : g_data_bit
            assign nbit = lo_src[LO_W-1-j];
         end else begin : g_zero_bit
            assign nbit = 1'b0;
         end

         assign trial  = {rem_src, nbit};
         assign ge     = trial >= {1'b0, dv_src};
         assign sub    = trial - {1'b0, dv_src};
         assign rem_in = ge ? sub[DIV_W-1:0] : trial[DIV_W-1:0];
         assign quo_in = {quo_src[QW-2:0], ge};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               quo_ff[j] <= quo_in;
               dv_ff[j]  <= dv_src;
               lo_ff[j]  <= lo_src;
            end
         end
      end
   endgenerate

   assign quo_out = quo_ff[DIV_STAGES-1];

endmodule

// ----- design/drive_command_plant_model_core.sv -----
// ----------------------------------------------------------------------------
// drive_command_plant_model_core
// Dead zone with rescale on both commands, gains, cross losses and drift.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; the whole pipeline halts only while a
// result waits at the output and is not taken.
// The 21-stage dead-zone divider sets the depth.
// Reset clears valid bits and loads the register defaults.
module drive_command_plant_model_core
   import dcpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   dcpm_req_if.sink     req_chan,
   dcpm_rsp_if.source   rsp_chan,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int NSTG = DIV_STAGES + 6;
   localparam int SM = DIV_STAGES + 1;   // products
   localparam int SF = DIV_STAGES + 2;   // loss factors
   localparam int SP = DIV_STAGES + 3;   // partial products
   localparam int SS = DIV_STAGES + 4;   // sums
   localparam int SR = DIV_STAGES + 5;   // rounded result

   // registers
   logic [31:0]        ldz_ff, adz_ff, lgain_ff;
   logic signed [15:0] again_ff, sloss_ff, yloss_ff, drift_ff, dofs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ldz_ff   <= '0;
         adz_ff   <= '0;
         lgain_ff <= 32'h0100_0100;
         again_ff <= 16'sd256;
         sloss_ff <= '0;
         yloss_ff <= '0;
         drift_ff <= '0;
         dofs_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_LIN_DZ:    ldz_ff   <= csr_wdata;
            REG_ANG_DZ:    adz_ff   <= csr_wdata;
            REG_LIN_GAIN:  lgain_ff <= csr_wdata;
            REG_ANG_GAIN:  again_ff <= csr_wdata[15:0];
            REG_SPD_LOSS:  sloss_ff <= csr_wdata[15:0];
            REG_YAW_LOSS:  yloss_ff <= csr_wdata[15:0];
            REG_DRIFT:     drift_ff <= csr_wdata[15:0];
            REG_DRIFT_OFS: dofs_ff  <= csr_wdata[15:0];
         endcase
      end
   end

   function automatic prep_type prep(input logic signed [15:0] u, input logic [31:0] dz);
      prep_type   p;
      logic [16:0] mag;
      logic [17:0] m;
      logic [15:0] d;
      begin
         p.neg = u[15];
         mag = u[15] ? (17'd0 - {u[15], u}) : {1'b0, u};
         m = {mag[15:0], 2'b00};
         if (mag[16]) m = 18'h20000;
         d = u[15] ? dz[15:0] : dz[31:16];
         if (d > DZ_MAX) d = DZ_MAX;
         p.diff = (m > {2'b00, d}) ? (m - {2'b00, d}) : '0;
         p.divisor = 17'h10000 - {1'b0, d};
         return p;
      end
   endfunction

   function automatic logic [24:0] loss(input logic signed [37:0] p);
      logic signed [38:0] f;
      logic [38:0]        s;
      begin
         f = 39'sh1000_0000 - {p[37], p};
         if (f[38]) f = '0;
         s = f + 39'd2048;
         return s[36:12];
      end
   endfunction

   function automatic logic [31:0] finish(input logic signed [63:0] x);
      logic [63:0] mag;
      logic [63:0] rnd;
      logic [39:0] m;
      logic [31:0] r;
      begin
         mag = x[63] ? (64'd0 - x) : x;
         rnd = mag + (64'd1 << 23);
         m = rnd[63:24];
         r = x[63] ? (32'd0 - m[31:0]) : m[31:0];
         if (!x[63] && m > 40'h7FFF_FFFF) r = 32'h7FFF_FFFF;
         if (x[63] && m > 40'h8000_0000) r = 32'h8000_0000;
         return r;
      end
   endfunction

   // flow control
   logic vld_ff [NSTG];
   logic adv;

   assign adv = !vld_ff[NSTG-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < NSTG; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 0: dead-zone prep
   prep_type pl_ff, pa_ff;
   logic     negl_ff [DIV_STAGES+1];
   logic     nega_ff [DIV_STAGES+1];
   prep_type pl_in, pa_in;

   assign pl_in = prep(req_chan.linear_command, ldz_ff);
   assign pa_in = prep(req_chan.turn_command, adz_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff <= pl_in;
         pa_ff <= pa_in;
         negl_ff[0] <= pl_in.neg;
         nega_ff[0] <= pa_in.neg;
         for (int i = 1; i <= DIV_STAGES; i++) begin
            negl_ff[i] <= negl_ff[i-1];
            nega_ff[i] <= nega_ff[i-1];
         end
      end
   end

   // divider stages
   logic [QW-1:0] quo_l, quo_a;

   dcpm_div u_div_lin (
      .clock(clock), .en(adv), .diff_in(pl_ff.diff), .div_in(pl_ff.divisor), .quo_out(quo_l)
   );
   dcpm_div u_div_ang (
      .clock(clock), .en(adv), .diff_in(pa_ff.diff), .div_in(pa_ff.divisor), .quo_out(quo_a)
   );

   // products
   logic signed [QW:0]  el, ea;
   logic                el_pos, el_neg;
   logic signed [15:0]  kgain;
   logic signed [37:0]  psb_ff, pad_ff, pke_ff, pae_ff, pdr_ff;
   logic                epos_ff [SM:SP];
   logic                eneg_ff [SM:SP];

   assign el = negl_ff[DIV_STAGES] ? -$signed({1'b0, quo_l}) : $signed({1'b0, quo_l});
   assign ea = nega_ff[DIV_STAGES] ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
   assign el_pos = !negl_ff[DIV_STAGES] && (quo_l != '0);
   assign el_neg = negl_ff[DIV_STAGES] && (quo_l != '0);
   assign kgain = el_neg ? $signed(lgain_ff[15:0]) : $signed(lgain_ff[31:16]);

   always_ff @(posedge clock) begin
      if (adv) begin
         psb_ff <= sloss_ff * $signed({1'b0, quo_a});
         pad_ff <= yloss_ff * $signed({1'b0, quo_l});
         pke_ff <= kgain * el;
         pae_ff <= again_ff * ea;
         pdr_ff <= drift_ff * el;
         epos_ff[SM] <= el_pos;
         eneg_ff[SM] <= el_neg;
         for (int i = SM + 1; i <= SP; i++) begin
            epos_ff[i] <= epos_ff[i-1];
            eneg_ff[i] <= eneg_ff[i-1];
         end
      end
   end

   // loss factors
   logic [24:0]        fsb_ff, fad_ff;
   logic signed [37:0] ke_ff, ae_ff, dr_f_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         fsb_ff  <= loss(psb_ff);
         fad_ff  <= loss(pad_ff);
         ke_ff   <= pke_ff;
         ae_ff   <= pae_ff;
         dr_f_ff <= pdr_ff;
      end
   end

   // partial products
   logic [42:0]        vlo_ff, wlo_ff;
   logic signed [45:0] vhi_ff, whi_ff;
   logic signed [37:0] dr_p_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         vlo_ff  <= ke_ff[17:0] * fsb_ff;
         vhi_ff  <= $signed(ke_ff[37:18]) * $signed({1'b0, fsb_ff});
         wlo_ff  <= ae_ff[17:0] * fad_ff;
         whi_ff  <= $signed(ae_ff[37:18]) * $signed({1'b0, fad_ff});
         dr_p_ff <= dr_f_ff;
      end
   end

   // sums
   logic signed [63:0] v_ff, w_ff;
   logic signed [63:0] v_in, w_in, ofs;

   always_comb begin
      ofs  = {{48{dofs_ff[15]}}, dofs_ff} <<< 28;
      v_in = $signed({21'd0, vlo_ff}) + ({{18{vhi_ff[45]}}, vhi_ff} <<< 18);
      w_in = $signed({21'd0, wlo_ff}) + ({{18{whi_ff[45]}}, whi_ff} <<< 18)
           + ({{26{dr_p_ff[37]}}, dr_p_ff} <<< 12);
      if (epos_ff[SP]) w_in = w_in + ofs;
      else if (eneg_ff[SP]) w_in = w_in - ofs;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff <= v_in;
         w_ff <= w_in;
      end
   end

   // round and saturate
   logic [31:0] lv_ff, yr_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         lv_ff <= finish(v_ff);
         yr_ff <= finish(w_ff);
      end
   end

   assign rsp_chan.valid           = vld_ff[SR];
   assign rsp_chan.linear_velocity = lv_ff;
   assign rsp_chan.yaw_rate        = yr_ff;

`ifndef SYNTHESIS
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && adv |=> vld_ff[0])
      else $error("accepted word not in first stage");

   a_quo_lin: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STAGES] |-> quo_l < E_LIMIT)
      else $error("linear rescale out of range");

   a_quo_ang: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STAGES] |-> quo_a < E_LIMIT)
      else $error("angular rescale out of range");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");
`endif

endmodule

// ----- tb/tb_drive_command_plant_model_core.sv -----
// ----------------------------------------------------------------------------
// tb_drive_command_plant_model_core
// Drives random and directed command words through the plant model core,
// predicts velocity and yaw rate in fixed point and checks every result word
// in order, across several register settings and with random stalls.
// ----------------------------------------------------------------------------
class plant_scoreboard;
   logic [31:0] lin_dz, ang_dz, lin_gain;
   logic signed [15:0] ang_gain, spd_loss, yaw_loss, drift_k, drift_ofs;
   logic [63:0] pending_q[$];
   int errors;

   function void load_defaults();
      lin_dz = 0; ang_dz = 0; lin_gain = 32'h01000100; ang_gain = 16'sd256;
      spd_loss = 0; yaw_loss = 0; drift_k = 0; drift_ofs = 0; errors = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
         dcpm_pkg::REG_LIN_DZ:    lin_dz = v;
         dcpm_pkg::REG_ANG_DZ:    ang_dz = v;
         dcpm_pkg::REG_LIN_GAIN:  lin_gain = v;
         dcpm_pkg::REG_ANG_GAIN:  ang_gain = v[15:0];
         dcpm_pkg::REG_SPD_LOSS:  spd_loss = v[15:0];
         dcpm_pkg::REG_YAW_LOSS:  yaw_loss = v[15:0];
         dcpm_pkg::REG_DRIFT:     drift_k = v[15:0];
         default:                 drift_ofs = v[15:0];
      endcase
   endfunction

   function longint rescaled(logic signed [15:0] u, logic [15:0] dpos, logic [15:0] dneg);
      longint d, m, q;
      d = (u >= 0) ? dpos : dneg;
      if (d > 62259) d = 62259;
      m = (u >= 0) ? u : -longint'(u);
      m = m * 4;
      q = (m > d) ? ((m - d) * 65536) / (65536 - d) : 0;
      return (u < 0) ? -q : q;
   endfunction

   function longint loss(logic signed [15:0] c, longint e);
      longint f;
      if (e < 0) e = -e;
      f = (longint'(1) <<< 28) - longint'(c) * e;
      if (f < 0) f = 0;
      return (f + 2048) / 4096;
   endfunction

   function logic [31:0] to_q16(longint x);
      logic [63:0] m;
      m = (x < 0) ? -x : x;
      m = (m + (64'd1 << 23)) >> 24;
      if (x >= 0 && m > 64'h7FFFFFFF) return 32'h7FFFFFFF;
      if (x < 0 && m > 64'h80000000) return 32'h80000000;
      return (x < 0) ? -m[31:0] : m[31:0];
   endfunction

   function void note_command(logic signed [15:0] lc, logic signed [15:0] tc);
      longint el, ea, v, w, k;
      el = rescaled(lc, lin_dz[31:16], lin_dz[15:0]);
      ea = rescaled(tc, ang_dz[31:16], ang_dz[15:0]);
      k = (el >= 0) ? longint'($signed(lin_gain[31:16])) : longint'($signed(lin_gain[15:0]));
      v = k * el * loss(spd_loss, ea);
      w = longint'(ang_gain) * ea * loss(yaw_loss, el) + longint'(drift_k) * el * 4096;
      if (el > 0) w = w + longint'(drift_ofs) * (longint'(1) <<< 28);
      else if (el < 0) w = w - longint'(drift_ofs) * (longint'(1) <<< 28);
      pending_q.push_back({to_q16(v), to_q16(w)});
   endfunction

   function void check_result(logic [31:0] vel, logic [31:0] yaw);
      logic [63:0] exp_w;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected word vel=%h yaw=%h", $time, vel, yaw);
         errors++;
         return;
      end
      exp_w = pending_q.pop_front();
      if (exp_w[63:32] !== vel) begin
         $display("%0t: linear_velocity expected %h actual %h", $time, exp_w[63:32], vel);
         errors++;
      end
      if (exp_w[31:0] !== yaw) begin
         $display("%0t: yaw_rate expected %h actual %h", $time, exp_w[31:0], yaw);
         errors++;
      end
   endfunction
endclass

module tb_drive_command_plant_model_core
   import dcpm_pkg::*;
();

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;
   bit hold_off = 0;
   bit random_stall = 1;
   int cycle_count = 0;
   plant_scoreboard board;

   dcpm_req_if req_chan();
   dcpm_rsp_if rsp_chan();

   drive_command_plant_model_core DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.linear_command = 0;
      req_chan.turn_command = 0;
      rsp_chan.ready = 0;
      board = new();
      board.load_defaults();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("tb_drive_command_plant_model_core: FAIL");
         $finish;
      end
   end

   // results checked at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_result(rsp_chan.linear_velocity, rsp_chan.yaw_rate);
   end

   // receiver: random stalls, or a long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 0;
            repeat (120) @(negedge clock);
            hold_off = 0;
         end
         gap = random_stall ? $urandom_range(0, 7) : 0;
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_chan.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1;
         @(negedge clock);
      end
   end

   task automatic send_command(logic signed [15:0] lc, logic signed [15:0] tc);
      int gap;
      gap = random_stall ? $urandom_range(0, 7) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.linear_command <= lc;
      req_chan.turn_command <= tc;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_command(lc, tc);
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req_chan.valid <= 0;
      @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      board.write_reg(idx, v);
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic drain();
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_command();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 600)) - 300);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_dz();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'd62259 + 16'($urandom_range(0, 2)) - 16'd1;
         default: return 16'($urandom_range(0, 40000));
      endcase
   endfunction

   function automatic logic [15:0] pick_coeff();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic random_settings();
      write_csr(REG_LIN_DZ, {pick_dz(), pick_dz()});
      write_csr(REG_ANG_DZ, {pick_dz(), pick_dz()});
      write_csr(REG_LIN_GAIN, {pick_coeff(), pick_coeff()});
      write_csr(REG_ANG_GAIN, {16'($urandom()), pick_coeff()});
      write_csr(REG_SPD_LOSS, {16'h0, pick_coeff()});
      write_csr(REG_YAW_LOSS, {16'h0, pick_coeff()});
      write_csr(REG_DRIFT, {16'h0, pick_coeff()});
      write_csr(REG_DRIFT_OFS, {16'h0, pick_coeff()});
   endtask

   initial begin
      logic [15:0] edge_vals [6];
      edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // reset defaults: extremes and small values
      foreach (edge_vals[i]) send_command(edge_vals[i], edge_vals[5 - i]);
      idle_sender();
      drain();

      // dead zones above the clamp, large gains and losses, drift
      write_csr(REG_LIN_DZ, 32'hFFFF_1000);
      write_csr(REG_ANG_DZ, 32'h2000_FFFF);
      write_csr(REG_LIN_GAIN, 32'h7FFF_8000);
      write_csr(REG_ANG_GAIN, 32'h0000_7FFF);
      write_csr(REG_SPD_LOSS, 32'h0000_1000);
      write_csr(REG_YAW_LOSS, 32'h0000_8000);
      write_csr(REG_DRIFT, 32'h0000_7FFF);
      write_csr(REG_DRIFT_OFS, 32'h0000_8000);
      foreach (edge_vals[i]) begin
         send_command(edge_vals[i], edge_vals[i]);
         send_command(edge_vals[i], ~edge_vals[i]);
      end
      send_command(16'sd3000, -16'sd200);
      send_command(-16'sd200, 16'sd3000);
      idle_sender();
      drain();

      // long receiver hold-off while the sender keeps going
      hold_off = 1;
      random_stall = 0;
      repeat (80) send_command(16'($urandom()), 16'($urandom()));
      random_stall = 1;
      idle_sender();
      drain();

      repeat (8) begin
         random_settings();
         repeat (80) send_command(pick_command(), pick_command());
         idle_sender();
         drain();
      end

      if (board.errors == 0)
         $display("tb_drive_command_plant_model_core: PASS");
      else
         $display("tb_drive_command_plant_model_core: FAIL");
      $finish;
   end
endmodule

// ----- drive_command_plant_model_core.f -----
design/dcpm_pkg.sv
design/dcpm_req_if.sv
design/dcpm_rsp_if.sv
design/dcpm_div.sv
design/drive_command_plant_model_core.sv
tb/tb_drive_command_plant_model_core.sv
